FILE: rtl/sbc_pkg.sv
package sbc_pkg;

   // Width of one sector number and of the reported slot
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 3;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } sbc_state_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;    // capture request beat, restart scan
      logic scan;    // issue one slot read, advance index
      logic commit;  // update slot state and load result register
   } sbc_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic last_issue;  // read of the last slot is being issued
      logic out_free;    // result register can take a new beat
   } sbc_status_type;

endpackage

FILE: rtl/sector_buffer_lfu_cache.sv
// Tag and replacement logic for a small fully associative sector buffer
// with least-frequently-used replacement.
//
// Request channel (req_valid/req_ready/req_sector): one beat per sector
// lookup. Response channel (rsp_valid/rsp_ready): one beat per request
// with rsp_hit, rsp_slot and rsp_fill_sector (the sector to load into
// rsp_slot on a miss, zero on a hit).
//
// Each request walks the slot table one slot per cycle through a single
// read port, so the slot count sets the latency. A new request beat is
// taken only once the result of the previous one has been loaded into
// the output register.
//
// The result sits in an output register; the next request is accepted and
// scanned while it waits. If the receiver still stalls when that next
// result is ready, the block holds it and takes no further request.
//
// Reset (synchronous, active high) clears all slot valid bits, so every
// slot is empty and counts as zero uses; no clearing pass is needed.
module sector_buffer_lfu_cache
   import sbc_pkg::*;
#(
   parameter int NUM_SLOTS   = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SECTOR_W-1:0] req_sector,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [SECTOR_W-1:0] rsp_fill_sector
);

   sbc_cmd_type    cmd;
   sbc_status_type status;

   sbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbc_datapath #(
      .NUM_SLOTS   (NUM_SLOTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sector      (req_sector),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_fill_sector (rsp_fill_sector)
   );

`ifndef SYNTHESIS
   // A hit never asks for a fill
   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_fill_sector == '0)
      else $error("fill sector reported on a hit");

   // A request beat starts a scan, so the block is busy next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a scan is running");

   // A new result only appears at the end of a scan
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result produced without a scan");
`endif

endmodule

FILE: rtl/sbc_ctrl.sv
module sbc_ctrl
   import sbc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sbc_status_type status,
   output sbc_cmd_type    cmd
);

   sbc_state_type state_ff;
   sbc_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_WRITE: begin
            cmd.commit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/sbc_datapath.sv
module sbc_datapath
   import sbc_pkg::*;
#(
   parameter int NUM_SLOTS   = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  sbc_cmd_type         cmd,
   output sbc_status_type      status,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [SECTOR_W-1:0] rsp_fill_sector
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   // Slot storage
   logic [SECTOR_W-1:0]    tag_mem [NUM_SLOTS];
   logic [COUNT_WIDTH-1:0] cnt_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   valid_ff;

   // Scan pipeline
   logic [SECTOR_W-1:0]    sector_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic                   cmp_vld_ff;
   logic [SECTOR_W-1:0]    tag_rd_ff;
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;

   // Scan results
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [COUNT_WIDTH-1:0] best_cnt_ff;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [SECTOR_W-1:0]    rsp_fill_ff;

   logic                   cur_valid;
   logic [COUNT_WIDTH-1:0] cur_cnt;
   logic                   cur_match;
   logic [IDX_W-1:0]       win_idx;
   logic [COUNT_WIDTH-1:0] new_cnt;

   assign status.last_issue = cmd.scan && (rd_idx_ff == LAST_IDX);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // Request capture and read index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sector_ff <= req_sector;
         rd_idx_ff <= '0;
      end else if (cmd.scan) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   // Registered slot reads
   always_ff @(posedge clock) begin
      tag_rd_ff  <= tag_mem[rd_idx_ff];
      cnt_rd_ff  <= cnt_mem[rd_idx_ff];
      cmp_idx_ff <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
      end
   end

   // Compare stage: invalid slots count as zero and never match
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_cnt   = cur_valid ? cnt_rd_ff : '0;
   assign cur_match = cur_valid && (tag_rd_ff == sector_ff);

   // Highest matching index and lowest count, ties to the higher index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff <= 1'b0;
      end else if (cmp_vld_ff) begin
         if (cur_match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
            hit_cnt_ff <= cur_cnt;
         end
         if ((cmp_idx_ff == '0) || (cur_cnt <= best_cnt_ff)) begin
            best_idx_ff <= cmp_idx_ff;
            best_cnt_ff <= cur_cnt;
         end
      end
   end

   assign win_idx = hit_ff ? hit_idx_ff : best_idx_ff;
   assign new_cnt = !hit_ff ? COUNT_ONE :
                    (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + 1'b1;

   // Slot update
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         cnt_mem[win_idx] <= new_cnt;
         if (!hit_ff) tag_mem[win_idx] <= sector_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[win_idx] <= 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= SLOT_W'(win_idx);
         rsp_fill_ff <= hit_ff ? '0 : sector_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_fill_sector = rsp_fill_ff;

endmodule
